// ===== design/assert_macros.svh =====
// Assertion macros for the design files; the decoder top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== design/hhd_pkg.sv =====
// Package: code tables, status codes and sequencer states of the HPACK Huffman decoder.
`timescale 1ns / 1ps

package hhd_pkg;

  localparam int NumSym = 257;           // 256 octets plus EOS
  localparam int NumLen = 32;            // code lengths held in 5 bits
  localparam logic [4:0] MaxLen = 5'd30; // longest code (EOS)
  localparam logic [8:0] EosIdx = 9'(NumSym - 1);

  typedef logic [NumLen-1:0][8:0] len_tab_t;
  typedef logic [NumSym-1:0][8:0] sym_tab_t;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadCode = 2'd1,
    StEos     = 2'd2,
    StBadPad  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmWalk,
    FsmFlush,
    FsmStatus
  } fsm_e;

  // Code length of each symbol (octets 0..255, then EOS).
  localparam int unsigned CodeLen [NumSym] = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
    30
  };

  // The code is canonical: within a length, codes rise with the symbol value,
  // so a leaf is found from (length, offset within length) alone.
  function automatic len_tab_t calc_count();
    len_tab_t c;
    c = '0;
    for (int s = 0; s < NumSym; s++) begin
      c[CodeLen[s]] = c[CodeLen[s]] + 9'd1;
    end
    return c;
  endfunction

  localparam len_tab_t LenCount = calc_count();

  function automatic len_tab_t calc_offset();
    len_tab_t   o;
    logic [8:0] acc;
    o   = '0;
    acc = '0;
    for (int l = 0; l < NumLen; l++) begin
      o[l] = acc;
      acc  = acc + LenCount[l];
    end
    return o;
  endfunction

  localparam len_tab_t LenOffset = calc_offset();

  // Symbols sorted by (length, value); EOS lands last.
  function automatic sym_tab_t calc_sorted();
    sym_tab_t t;
    int       k;
    t = '0;
    k = 0;
    for (int l = 1; l < NumLen; l++) begin
      for (int s = 0; s < NumSym; s++) begin
        if (CodeLen[s] == l) begin
          t[k] = 9'(s);
          k    = k + 1;
        end
      end
    end
    return t;
  endfunction

  localparam sym_tab_t SortedSym = calc_sorted();

endpackage

// ===== design/hpack_huffman_decoder_top.sv =====
// Top level: bit-serial canonical HPACK Huffman decoder with result register.
// Each byte walks up to 8 code bits, one per cycle unless a full result register holds the
// walk, through a single step unit (subtract, shift, compare against the per-length code count);
// the walk stops early on EOS or an invalid code, and no new byte is taken until the byte is done.
// A byte dropped after an error is accepted in idle without a walk.
// Reset (rst_ni low, async) returns the walk to the root, clears the error and empties the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpack_huffman_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic       symbol_valid_o,
  output logic [1:0] status_o,
  output logic       end_of_run_o
);
  import hhd_pkg::*;

  fsm_e       state_q, state_d;

  // walk state
  logic [4:0] len_q, len_d;
  logic [8:0] v_q, v_d;
  logic       ones_q, ones_d;
  logic       err_seen_q, err_seen_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] byte_q, byte_d;
  logic       final_q, final_d;

  // symbol held back until it is known whether it closes the byte
  logic       pend_vld_q, pend_vld_d;
  logic [8:0] pend_idx_q, pend_idx_d;
  logic       stat_vld_q, stat_vld_d;
  status_e    stat_q, stat_d;

  // result register
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_sym_q, out_sym_d;
  logic       out_sv_q, out_sv_d;
  status_e    out_stat_q, out_stat_d;
  logic       out_eor_q, out_eor_d;

  logic       in_acc;
  logic       out_free;
  logic       cur_bit;
  logic [7:0] rel;
  logic [4:0] nxt_len;
  logic [8:0] nv;
  logic       is_leaf;
  logic [8:0] leaf_idx;
  logic       is_eos;
  logic       is_miss;
  logic       last_bit;
  logic       walk_hold;

  assign in_stall_o = (state_q != FsmIdle);
  assign in_acc     = in_valid_i && (state_q == FsmIdle);
  assign out_free   = !out_vld_q || !out_stall_i;

  // step unit: v is the code value relative to the first code of length len
  assign cur_bit   = byte_q[7];
  assign rel       = 8'(v_q - LenCount[len_q]);
  assign nxt_len   = len_q + 5'd1;
  assign nv        = {rel, cur_bit};
  assign is_leaf   = (nv < LenCount[nxt_len]);
  assign leaf_idx  = 9'(LenOffset[nxt_len] + nv);
  assign is_eos    = is_leaf && (leaf_idx == EosIdx);
  assign is_miss   = !is_leaf && (nxt_len == MaxLen);
  assign last_bit  = (cnt_q == 3'd7);
  assign walk_hold = (state_q == FsmWalk) && is_leaf && !is_eos && pend_vld_q && !out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: begin
        if (in_acc && !err_seen_q) state_d = FsmWalk;
      end
      FsmWalk: begin
        if (!walk_hold && (is_eos || is_miss || last_bit)) state_d = FsmFlush;
      end
      FsmFlush: begin
        if (!(pend_vld_q && !out_free)) state_d = stat_vld_q ? FsmStatus : FsmIdle;
      end
      FsmStatus: begin
        if (out_free) state_d = FsmIdle;
      end
      default: state_d = FsmIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_d      = len_q;
    v_d        = v_q;
    ones_d     = ones_q;
    err_seen_d = err_seen_q;
    cnt_d      = cnt_q;
    byte_d     = byte_q;
    final_d    = final_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    stat_vld_d = stat_vld_q;
    stat_d     = stat_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_sym_d  = out_sym_q;
    out_sv_d   = out_sv_q;
    out_stat_d = out_stat_q;
    out_eor_d  = out_eor_q;

    case (state_q)
      FsmIdle: begin
        if (in_acc) begin
          if (err_seen_q) begin
            // dropped byte; the final one ends the string
            if (final_byte_i) err_seen_d = 1'b0;
          end else begin
            byte_d  = code_byte_i;
            final_d = final_byte_i;
            cnt_d   = '0;
          end
        end
      end
      FsmWalk: begin
        if (!walk_hold) begin
          byte_d = {byte_q[6:0], 1'b0};
          cnt_d  = cnt_q + 3'd1;
          if (is_eos || is_miss) begin
            stat_d     = is_eos ? StEos : StBadCode;
            stat_vld_d = 1'b1;
            len_d      = '0;
            v_d        = '0;
            ones_d     = 1'b1;
            err_seen_d = !final_q;
          end else if (is_leaf) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_sym_d  = SortedSym[pend_idx_q][7:0];
              out_sv_d   = 1'b1;
              out_stat_d = StOk;
              out_eor_d  = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = leaf_idx;
            len_d      = '0;
            v_d        = '0;
            ones_d     = 1'b1;
            if (last_bit && final_q) begin
              stat_d     = StOk;
              stat_vld_d = 1'b1;
            end
          end else begin
            len_d  = nxt_len;
            v_d    = nv;
            ones_d = ones_q & cur_bit;
            if (last_bit && final_q) begin
              // a partial code is left; only ones may pad it
              stat_d     = (ones_q & cur_bit) ? StOk : StBadPad;
              stat_vld_d = 1'b1;
              len_d      = '0;
              v_d        = '0;
              ones_d     = 1'b1;
            end
          end
        end
      end
      FsmFlush: begin
        if (pend_vld_q && out_free) begin
          out_vld_d  = 1'b1;
          out_sym_d  = SortedSym[pend_idx_q][7:0];
          out_sv_d   = 1'b1;
          out_stat_d = StOk;
          out_eor_d  = !stat_vld_q;
          pend_vld_d = 1'b0;
        end
      end
      FsmStatus: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_sym_d  = '0;
          out_sv_d   = 1'b0;
          out_stat_d = stat_q;
          out_eor_d  = 1'b1;
          stat_vld_d = 1'b0;
        end
      end
      default: begin
        pend_vld_d = 1'b0;
        stat_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FsmIdle;
      len_q      <= '0;
      v_q        <= '0;
      ones_q     <= 1'b1;
      err_seen_q <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      stat_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      v_q        <= v_d;
      ones_q     <= ones_d;
      err_seen_q <= err_seen_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      stat_vld_q <= stat_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    final_q    <= final_d;
    pend_idx_q <= pend_idx_d;
    stat_q     <= stat_d;
    out_sym_q  <= out_sym_d;
    out_sv_q   <= out_sv_d;
    out_stat_q <= out_stat_d;
    out_eor_q  <= out_eor_d;
  end

  assign out_valid_o    = out_vld_q;
  assign symbol_o       = out_sym_q;
  assign symbol_valid_o = out_sv_q;
  assign status_o       = out_stat_q;
  assign end_of_run_o   = out_eor_q;

  `ASSERT_NEVER(a_len_range, len_q >= MaxLen, "walk depth reached the longest code length")
  `ASSERT_CLK(a_pend_not_eos, pend_vld_q |-> (pend_idx_q != EosIdx),
              "EOS held as a symbol")
  `ASSERT_CLK(a_err_closes, (out_vld_q && (out_stat_q != StOk)) |-> (out_eor_q && !out_sv_q),
              "error result not closing its byte")
  `ASSERT_CLK(a_idle_empty, (state_q == FsmIdle) |-> (!pend_vld_q && !stat_vld_q),
              "idle with undelivered results")
  `ASSERT_CLK(a_drop_at_root, err_seen_q |-> (len_q == 5'd0 && ones_q),
              "dropping bytes with a partial code")

endmodule

// ===== bench/hpack_huffman_decoder_checker.sv =====
// Checker for the HPACK Huffman decoder: predicts each byte's results and compares them.
`timescale 1ns / 1ps

module hpack_huffman_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] code_byte_i,
  input  logic       final_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] symbol_i,
  input  logic       symbol_valid_i,
  input  logic [1:0] status_i,
  input  logic       end_of_run_i,
  output int         mismatch_cnt_o,
  output int         outstanding_o,
  output int         results_o
);
  import hhd_pkg::*;

  localparam int NumCodes = 257;
  localparam int EosCode  = 256;
  localparam int LeafFlag = 'h200;
  localparam int MaxShown = 10;

  // Code length per octet, EOS last.
  localparam int CodeWidth [NumCodes] = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
    30
  };

  typedef struct packed {
    logic [7:0] sym;
    logic       sym_ok;
    status_e    st;
    logic       eor;
  } sym_result_t;

  // Decode tree: 0 = no branch, LeafFlag | symbol = leaf, else next node index.
  int          tree_next [256][2];
  logic [31:0] sym_code [NumCodes];

  logic [7:0]  walk_node;
  logic        ones_run;
  logic        dropping;
  sym_result_t pending_results [$];
  int          mismatches;
  int          results_seen;

  // The code is canonical, so codes follow from the lengths alone.
  initial begin : build_tree
    logic [31:0] next_code;
    int          used;
    int          node;
    int          b;
    next_code = '0;
    for (int l = 1; l <= 30; l++) begin
      for (int s = 0; s < NumCodes; s++) begin
        if (CodeWidth[s] == l) begin
          sym_code[s] = next_code;
          next_code   = next_code + 1;
        end
      end
      next_code = next_code << 1;
    end
    for (int n = 0; n < 256; n++) begin
      tree_next[n][0] = 0;
      tree_next[n][1] = 0;
    end
    used = 1;
    for (int s = 0; s < NumCodes; s++) begin
      node = 0;
      for (int i = CodeWidth[s] - 1; i >= 0; i--) begin
        b = sym_code[s][i];
        if (i == 0) begin
          tree_next[node][b] = LeafFlag | s;
        end else begin
          if (tree_next[node][b] == 0) begin
            tree_next[node][b] = used;
            used = used + 1;
          end
          node = tree_next[node][b];
        end
      end
    end
  end

  function automatic sym_result_t make_result(input logic [7:0] s, input logic ok,
                                              input status_e st);
    sym_result_t r;
    r.sym    = s;
    r.sym_ok = ok;
    r.st     = st;
    r.eor    = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] cb, input logic fin);
    logic [7:0]  node;
    logic        ones;
    status_e     err;
    int          n;
    int          c;
    int          i;
    sym_result_t res [3];
    node = walk_node;
    ones = ones_run;
    err  = StOk;
    n    = 0;
    if (dropping) begin
      // rest of a failed string: silent, the final byte rearms the decoder
      if (fin) begin
        dropping  = 1'b0;
        walk_node = '0;
        ones_run  = 1'b1;
      end
    end else begin
      for (i = 7; i >= 0 && err == StOk; i--) begin
        c = tree_next[node][cb[i]];
        if (c == 0) begin
          err = StBadCode;
        end else if ((c & LeafFlag) != 0) begin
          if ((c & 'h1ff) == EosCode) begin
            err = StEos;
          end else begin
            if (n < 2) begin
              res[n] = make_result(c[7:0], 1'b1, StOk);
              n++;
            end
            node = '0;
            ones = 1'b1;
          end
        end else begin
          node = c[7:0];
          ones = ones & cb[i];
        end
      end
      if (err != StOk) begin
        res[n]    = make_result('0, 1'b0, err);
        n++;
        walk_node = '0;
        ones_run  = 1'b1;
        dropping  = !fin;
      end else if (fin) begin
        // leftover bits must be ones along the EOS path
        res[n]    = make_result('0, 1'b0, (node != '0 && !ones) ? StBadPad : StOk);
        n++;
        walk_node = '0;
        ones_run  = 1'b1;
      end else begin
        walk_node = node;
        ones_run  = ones;
      end
      if (n > 0) res[n-1].eor = 1'b1;
      for (int k = 0; k < n; k++) pending_results = {pending_results, res[k]};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sym_result_t want;
    if (!rst_ni) begin
      walk_node    = '0;
      ones_run     = 1'b1;
      dropping     = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      pending_results.delete();
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
      results_o      <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_byte(code_byte_i, final_byte_i);
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("result %0d: none expected, got sym %02h valid %0b status %0d end %0b",
                     results_seen, symbol_i, symbol_valid_i, status_i, end_of_run_i);
        end else begin
          want = pending_results.pop_front();
          if (symbol_i !== want.sym || symbol_valid_i !== want.sym_ok ||
              status_i !== want.st || end_of_run_i !== want.eor) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display({"result %0d: expected sym %02h valid %0b status %0d end %0b,",
                        " got sym %02h valid %0b status %0d end %0b"},
                       results_seen, want.sym, want.sym_ok, want.st, want.eor,
                       symbol_i, symbol_valid_i, status_i, end_of_run_i);
          end
        end
      end
      mismatch_cnt_o <= mismatches;
      outstanding_o  <= pending_results.size();
      results_o      <= results_seen;
    end
  end

endmodule

// ===== bench/hpack_huffman_decoder_top_tb.sv =====
// Testbench top for the HPACK Huffman decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module hpack_huffman_decoder_top_tb;
  import hhd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 64;
  localparam int PhaseBytes  = 50;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] code_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic [1:0] status;
  logic       end_of_run;

  int          fail_count;
  int          outstanding;
  int          results_seen;
  int          idle_pct;
  int          stall_pct;
  int          cycle_cnt;
  int          bytes_sent;
  int          strings_sent;
  logic [31:0] huff_code [NumSym];
  logic        bitq [$];

  hpack_huffman_decoder_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .code_byte_i    (code_byte),
    .final_byte_i   (final_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .symbol_o       (symbol),
    .symbol_valid_o (symbol_valid),
    .status_o       (status),
    .end_of_run_o   (end_of_run)
  );

  hpack_huffman_decoder_checker u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .code_byte_i    (code_byte),
    .final_byte_i   (final_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .symbol_i       (symbol),
    .symbol_valid_i (symbol_valid),
    .status_i       (status),
    .end_of_run_i   (end_of_run),
    .mismatch_cnt_o (fail_count),
    .outstanding_o  (outstanding),
    .results_o      (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("hpack_huffman_decoder_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    code_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_code(input int sym);
    for (int i = CodeLen[sym] - 1; i >= 0; i--) bitq = {bitq, huff_code[sym][i]};
  endtask

  task automatic pad_ones();
    while (bitq.size() % 8 != 0) bitq = {bitq, 1'b1};
  endtask

  // Sends the queued bits as whole bytes, the last one marked final.
  task automatic send_bits();
    logic [7:0] b;
    while (bitq.size() >= 8) begin
      for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
      send_byte(b, bitq.size() == 0);
    end
    strings_sent++;
  endtask

  task automatic send_string();
    int kind;
    int n;
    int sym;
    kind = $urandom_range(99);
    n    = $urandom_range(1, 6);
    bitq.delete();
    if (kind < 12) begin
      // noise: raw bytes, final marks at random
      for (int k = 0; k < n; k++)
        send_byte(8'($urandom_range(255)), (k == n - 1) || ($urandom_range(7) == 0));
      strings_sent++;
    end else begin
      for (int k = 0; k < n; k++) begin
        sym = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(32, 126);
        push_code(sym);
        if (kind >= 82 && k == n / 2) push_code(NumSym - 1);
      end
      if (kind >= 70 && kind < 82) begin
        // padding with at least one zero bit
        bitq = {bitq, 1'b0};
        while (bitq.size() % 8 != 0) bitq = {bitq, 1'($urandom_range(1))};
      end else begin
        pad_ones();
        if ($urandom_range(5) == 0) repeat (8) bitq = {bitq, 1'b1};
      end
      send_bits();
    end
  endtask

  task automatic n_target_loop(input int target);
    while (bytes_sent < target) send_string();
  endtask

  initial begin : stimulus
    logic [31:0] next_code;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    code_byte  = '0;
    final_byte = 1'b0;
    out_stall  = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    cycle_cnt  = 0;
    bytes_sent = 0;
    strings_sent = 0;
    next_code  = '0;
    for (int l = 1; l <= int'(MaxLen); l++) begin
      for (int s = 0; s < NumSym; s++) begin
        if (CodeLen[s] == l) begin
          huff_code[s] = next_code;
          next_code    = next_code + 1;
        end
      end
      next_code = next_code << 1;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // '0' followed by three zero bits: bad padding
    send_byte(8'h00, 1'b1);
    // 'a' with ones padding
    send_byte(8'h1F, 1'b1);
    // second byte finishes '1', then ' ', then closes: three results
    send_byte(8'h00, 1'b0);
    send_byte(8'h54, 1'b1);
    // eight bits of padding, accepted
    send_byte(8'hFF, 1'b1);
    // EOS completed in the final byte
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // EOS mid-string, then dropped bytes up to the final one
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h1F, 1'b1);
    // long octet codes, spanning bytes
    bitq.delete();
    push_code(10);
    push_code(255);
    pad_ones();
    send_bits();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      n_target_loop(bytes_sent + PhaseBytes);
    end
    in_valid  <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d coded bytes in %0d strings; %0d results checked.",
             bytes_sent, strings_sent, results_seen);
    $display("Idle/stall mixes: none, sender 70%%, receiver 70%%, both 16%%.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("hpack_huffman_decoder_top_tb OK");
    end else begin
      $display("hpack_huffman_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
